### hdl/gfr_pkg.sv
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types and constants of the gamepad frame receiver: item codes,
// link codes, frame marker bytes, divider sizes and the control interface.
// ----------------------------------------------------------------------------
`default_nettype none

package gfr_pkg;

  // item kinds
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_OVF  = 2'd2;

  // link status codes
  localparam logic [1:0] LINK_UP   = 2'd0;
  localparam logic [1:0] LINK_GONE = 2'd1;
  localparam logic [1:0] LINK_OFF  = 2'd2;

  // frame marker bytes
  localparam logic [7:0] HEAD_BYTE = 8'h0D;
  localparam logic [7:0] TAIL_BYTE = 8'h0A;
  localparam logic [7:0] GONE_BYTE = 8'hAB;

  // axis divider sizes
  localparam int DVD_W = 45;
  localparam int DVS_W = 30;
  localparam int QUO_W = 17;

  // controller to datapath commands
  typedef struct packed {
    logic       take;
    logic       stick_max;
    logic       dz_mul;
    logic       dz_diff;
    logic       ax_mul1;
    logic       ax_mul2;
    logic       div_start;
    logic       ax_write;
    logic [1:0] axis;
    logic       load_out;
  } gfr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic emit_frame;
    logic emit_down;
    logic div_busy;
    logic out_free;
  } gfr_sts_t;

endpackage

`default_nettype wire

### hdl/gamepad_frame_receiver.sv
// Flow: a byte, tick or overflow that makes no report leaves the input free; a
// disconnect or offline report goes through S_PUSH into the output register.
// A completed frame stalls the input until its report is loaded: each axis
// runs S_MUL1, S_MUL2, S_DIVS, S_DIVW and S_WRITE around a 17-bit divide in one
// shared restoring divider, plus three setup steps per stick; a stalled output adds to this.
// Reset: synchronous, active high; counters and ages clear, link reads offline.
// ----------------------------------------------------------------------------
// gamepad_frame_receiver
// Builds 8-byte gamepad frames from UART bytes and reports buttons, edges,
// deadzoned stick axes, link status and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_frame_receiver (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         opcode,
  input  wire  [7:0]         data_byte,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         link_status,
  output logic [15:0]        buttons,
  output logic [15:0]        pressed,
  output logic [15:0]        released,
  output logic [31:0]        event_total,
  output logic signed [15:0] left_x,
  output logic signed [15:0] left_y,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic [31:0]        frames_total,
  output logic [31:0]        signals_total
);
  import gfr_pkg::*;

  gfr_cmd_t cmd;
  gfr_sts_t sts;

  gfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gfr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .data_byte     (data_byte),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .link_status   (link_status),
    .buttons       (buttons),
    .pressed       (pressed),
    .released      (released),
    .event_total   (event_total),
    .left_x        (left_x),
    .left_y        (left_y),
    .right_x       (right_x),
    .right_y       (right_y),
    .frames_total  (frames_total),
    .signals_total (signals_total)
  );

`ifndef SYNTHESIS
  // a button cannot be both pressed and released in one report
  a_edges_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pressed & released) == 16'd0)
    else $error("pressed and released overlap");

  // pressed buttons are among the current buttons
  a_pressed_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pressed & ~buttons) == 16'd0)
    else $error("pressed bit not in buttons");

  // link-down reports carry no buttons and centered sticks
  a_down_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && link_status != LINK_UP |->
      buttons == 16'd0 && left_x == 16'sd0 && left_y == 16'sd0 &&
      right_x == 16'sd0 && right_y == 16'sd0)
    else $error("link-down report with live data");
`endif

endmodule

`default_nettype wire

### hdl/gfr_div.sv
// ----------------------------------------------------------------------------
// gfr_div
// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in QUO_W bits, so only the low QUO_W dividend bits are stepped through.
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_div (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire [gfr_pkg::DVD_W-1:0]   dividend,
  input  wire [gfr_pkg::DVS_W-1:0]   divisor,
  output logic                       busy,
  output logic [gfr_pkg::QUO_W-1:0]  quotient
);
  import gfr_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [QUO_W-1:0] sh;
  logic [4:0]       cnt;
  logic [DVS_W:0]   trial;
  logic             fits;

  // trial subtract of the next bit
  assign trial = {rem, sh[QUO_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(QUO_W);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DVS_W'(dividend[DVD_W-1:QUO_W]);
      sh  <= dividend[QUO_W-1:0];
    end else if (busy) begin
      if (fits) begin
        rem <= DVS_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DVS_W-1:0];
      end
      sh <= {sh[QUO_W-2:0], fits};
    end
  end

  assign quotient = sh;

endmodule

`default_nettype wire

### hdl/gfr_ctrl.sv
// ----------------------------------------------------------------------------
// gfr_ctrl
// Controller: takes items, sequences the four axis computations of a frame
// report and hands each report to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  gfr_pkg::gfr_sts_t  sts,
  output gfr_pkg::gfr_cmd_t  cmd
);
  import gfr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAX   = 4'd1;
  localparam logic [3:0] S_DZM   = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_MUL1  = 4'd4;
  localparam logic [3:0] S_MUL2  = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] axis, axis_next;

  assign in_stall = state != S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    axis_next  = axis;
    cmd        = '0;
    cmd.axis   = axis;
    case (state)
      S_IDLE: begin
        cmd.take = in_valid;
        if (in_valid) begin
          if (sts.emit_frame) begin
            state_next = S_MAX;
            axis_next  = 2'd0;
          end else if (sts.emit_down) begin
            state_next = S_PUSH;
          end
        end
      end
      S_MAX: begin
        cmd.stick_max = 1'b1;
        state_next    = S_DZM;
      end
      S_DZM: begin
        cmd.dz_mul = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.dz_diff = 1'b1;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.ax_mul1 = 1'b1;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.ax_mul2 = 1'b1;
        state_next  = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.ax_write = 1'b1;
        axis_next    = axis + 2'd1;
        if (axis == 2'd3) begin
          state_next = S_PUSH;
        end else if (axis[0]) begin
          state_next = S_MAX;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 2'd0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule

`default_nettype wire

### hdl/gfr_dp.sv
// ----------------------------------------------------------------------------
// gfr_dp
// Datapath: configuration registers, frame store, ages, counters, the axis
// arithmetic with its divider, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gfr_dp (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire  [1:0]         cfg_index,
  input  wire  [15:0]        cfg_data,
  input  wire  [1:0]         opcode,
  input  wire  [7:0]         data_byte,
  input  gfr_pkg::gfr_cmd_t  cmd,
  output gfr_pkg::gfr_sts_t  sts,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         link_status,
  output logic [15:0]        buttons,
  output logic [15:0]        pressed,
  output logic [15:0]        released,
  output logic [31:0]        event_total,
  output logic signed [15:0] left_x,
  output logic signed [15:0] left_y,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic [31:0]        frames_total,
  output logic [31:0]        signals_total
);
  import gfr_pkg::*;

  localparam logic [1:0]  REG_DEADZONE = 2'd0;
  localparam logic [1:0]  REG_FRAME_TO = 2'd1;
  localparam logic [1:0]  REG_OFF_TO   = 2'd2;
  localparam logic [16:0] AGE_MAX      = 17'h1FFFF;
  localparam logic [7:0]  X_MID        = 8'd127;
  localparam logic [7:0]  Y_MID        = 8'd128;

  // configuration
  logic [14:0] deadzone;
  logic [15:0] frame_timeout;
  logic [15:0] offline_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone        <= 15'd3277;
      frame_timeout   <= 16'd100;
      offline_timeout <= 16'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEADZONE: deadzone        <= cfg_data[14:0];
        REG_FRAME_TO: frame_timeout   <= cfg_data;
        REG_OFF_TO:   offline_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // receiver state
  logic [7:0]  store [8];
  logic [7:0]  store_next [8];
  logic [7:0]  full [8];
  logic [2:0]  fill, fill_next;
  logic [16:0] partial_age, pa_next, pa_inc;
  logic [16:0] silence_age, sa_next, sa_inc;
  logic [1:0]  link_held, link_next;
  logic [15:0] held, held_next;
  logic [31:0] event_count, ev_next;
  logic [31:0] frm_count, fr_next;
  logic [31:0] sig_count, sg_next;
  logic [1:0]  pend_link, pend_link_next;
  logic [15:0] pend_buttons, pend_buttons_next;
  logic [15:0] pend_pressed, pend_pressed_next;
  logic [15:0] pend_released, pend_released_next;
  logic [2:0]  sel;
  logic        found;
  logic [3:0]  nf;
  logic [15:0] cur, prs, rel;
  logic        emit_frame, emit_down;
  logic [1:0]  down_code;

  // item handling, applied when an item is taken
  always_comb begin
    fill_next          = fill;
    pa_next            = partial_age;
    sa_next            = silence_age;
    link_next          = link_held;
    held_next          = held;
    ev_next            = event_count;
    fr_next            = frm_count;
    sg_next            = sig_count;
    pend_link_next     = pend_link;
    pend_buttons_next  = pend_buttons;
    pend_pressed_next  = pend_pressed;
    pend_released_next = pend_released;
    store_next         = store;
    full               = store;
    full[7]            = data_byte;
    emit_frame         = 1'b0;
    emit_down          = 1'b0;
    down_code          = LINK_UP;
    sel                = 3'd0;
    found              = 1'b0;
    // latest header byte at index 1 to 7
    for (int i = 1; i < 8; i++) begin
      if (full[i] == HEAD_BYTE) begin
        sel   = 3'(i);
        found = 1'b1;
      end
    end
    pa_inc = (partial_age == AGE_MAX) ? partial_age : partial_age + 17'd1;
    sa_inc = (silence_age == AGE_MAX) ? silence_age : silence_age + 17'd1;
    nf     = {1'b0, fill} + 4'd1;
    cur    = {store[1], store[2]};
    prs    = cur & ~held;
    rel    = held & ~cur;
    if (cmd.take) begin
      case (opcode)
        OP_TICK: begin
          if (fill != 3'd0) begin
            if (pa_inc > {1'b0, frame_timeout}) begin
              fill_next = 3'd0;
              pa_next   = '0;
            end else begin
              pa_next = pa_inc;
            end
          end
          sa_next = sa_inc;
          if (sa_inc > {1'b0, offline_timeout} && link_held != LINK_OFF) begin
            emit_down = 1'b1;
            down_code = LINK_OFF;
          end
        end
        OP_OVF: begin
          fill_next = 3'd0;
          pa_next   = '0;
        end
        OP_BYTE: begin
          if (fill == 3'd0) begin
            if (data_byte == HEAD_BYTE) begin
              store_next[0] = data_byte;
              fill_next     = 3'd1;
              pa_next       = '0;
            end else if (data_byte == GONE_BYTE) begin
              sg_next   = sig_count + 32'd1;
              sa_next   = '0;
              emit_down = 1'b1;
              down_code = LINK_GONE;
            end
          end else begin
            store_next[fill] = data_byte;
            pa_next          = '0;
            if (nf == 4'd8) begin
              if (store[0] == HEAD_BYTE && data_byte == TAIL_BYTE) begin
                fill_next  = 3'd0;
                emit_frame = 1'b1;
                fr_next    = frm_count + 32'd1;
                sg_next    = sig_count + 32'd1;
                sa_next    = '0;
                link_next  = LINK_UP;
              end else begin
                // resync on the latest header byte
                for (int j = 0; j < 8; j++) begin
                  store_next[j] = full[3'(j) + sel];
                end
                fill_next = found ? 3'(4'd8 - {1'b0, sel}) : 3'd0;
              end
            end else begin
              fill_next = nf[2:0];
            end
          end
        end
        default: ;
      endcase
    end
    // disconnect or offline report
    if (emit_down) begin
      ev_next            = (held != 16'd0) ? event_count + 32'd1 : event_count;
      held_next          = '0;
      link_next          = down_code;
      pend_link_next     = down_code;
      pend_buttons_next  = '0;
      pend_pressed_next  = '0;
      pend_released_next = held;
    end
    // frame report
    if (emit_frame) begin
      ev_next            = ((prs | rel) != 16'd0) ? event_count + 32'd1 : event_count;
      held_next          = cur;
      pend_link_next     = LINK_UP;
      pend_buttons_next  = cur;
      pend_pressed_next  = prs;
      pend_released_next = rel;
    end
  end

  always_ff @(posedge clk) begin
    store         <= store_next;
    pend_link     <= pend_link_next;
    pend_buttons  <= pend_buttons_next;
    pend_pressed  <= pend_pressed_next;
    pend_released <= pend_released_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      partial_age <= '0;
      silence_age <= '0;
      link_held   <= LINK_OFF;
      held        <= '0;
      event_count <= '0;
      frm_count   <= '0;
      sig_count   <= '0;
    end else begin
      fill        <= fill_next;
      partial_age <= pa_next;
      silence_age <= sa_next;
      link_held   <= link_next;
      held        <= held_next;
      event_count <= ev_next;
      frm_count   <= fr_next;
      sig_count   <= sg_next;
    end
  end

  // axis normalization: {negative, magnitude, denominator}
  function automatic logic [16:0] norm_x(input logic [7:0] raw);
    logic neg;
    neg = raw < X_MID;
    return {neg, neg ? X_MID - raw : raw - X_MID, neg ? 8'd127 : 8'd128};
  endfunction

  // y axes come out negated
  function automatic logic [16:0] norm_y(input logic [7:0] raw);
    logic up;
    up = raw >= Y_MID;
    return {raw > Y_MID, up ? raw - Y_MID : Y_MID - raw, up ? 8'd127 : 8'd128};
  endfunction

  logic [16:0] sx, sy, ca;
  logic [7:0]  raw_a;
  logic [15:0] xcross, ycross;
  logic [7:0]  mn, md;
  logic [22:0] dzmd;
  logic [23:0] diff;
  logic        live;
  logic [14:0] dmn;
  logic [29:0] anf;
  logic [29:0] bot;
  logic [15:0] dzc;
  logic [15:0] axv [4];
  logic [15:0] axv_new;
  logic [DVD_W-1:0] dividend;
  logic [QUO_W-1:0] quot;
  logic             div_busy;

  // operand selection for the current stick and axis
  always_comb begin
    sx = norm_x(cmd.axis[1] ? store[6] : store[4]);
    sy = norm_y(cmd.axis[1] ? store[5] : store[3]);
    case (cmd.axis)
      2'd0:    raw_a = store[4];
      2'd1:    raw_a = store[3];
      2'd2:    raw_a = store[6];
      default: raw_a = store[5];
    endcase
    ca = cmd.axis[0] ? norm_y(raw_a) : norm_x(raw_a);
  end

  assign xcross   = {8'd0, sx[15:8]} * {8'd0, sy[7:0]};
  assign ycross   = {8'd0, sy[15:8]} * {8'd0, sx[7:0]};
  assign dzc      = 16'(17'd32768 - {2'b0, deadzone});
  assign dividend = {anf, 15'd0} + DVD_W'(bot[29:1]);

  // axis arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.stick_max) begin
      if (xcross >= ycross) begin
        mn <= sx[15:8];
        md <= sx[7:0];
      end else begin
        mn <= sy[15:8];
        md <= sy[7:0];
      end
    end
    if (cmd.dz_mul) begin
      dzmd <= {8'd0, deadzone} * {15'd0, md};
    end
    if (cmd.dz_diff) begin
      diff <= {1'b0, mn, 15'd0} - {1'b0, dzmd};
      live <= ({1'b0, mn, 15'd0} > {1'b0, dzmd});
    end
    if (cmd.ax_mul1) begin
      dmn <= 15'({8'd0, ca[7:0]} * {8'd0, mn});
      anf <= {22'd0, ca[15:8]} * {7'd0, diff[22:0]};
    end
    if (cmd.ax_mul2) begin
      bot <= {15'd0, dmn} * {14'd0, dzc};
    end
    if (cmd.ax_write) begin
      axv[cmd.axis] <= axv_new;
    end
  end

  // sign, clamp and deadzone of the quotient
  always_comb begin
    if (!live) begin
      axv_new = '0;
    end else if (ca[16]) begin
      axv_new = 16'(17'd0 - quot);
    end else if (quot > 17'd32767) begin
      axv_new = 16'd32767;
    end else begin
      axv_new = quot[15:0];
    end
  end

  gfr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (bot),
    .busy     (div_busy),
    .quotient (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      link_status   <= pend_link;
      buttons       <= pend_buttons;
      pressed       <= pend_pressed;
      released      <= pend_released;
      event_total   <= event_count;
      frames_total  <= frm_count;
      signals_total <= sig_count;
      left_x        <= (pend_link == LINK_UP) ? axv[0] : 16'd0;
      left_y        <= (pend_link == LINK_UP) ? axv[1] : 16'd0;
      right_x       <= (pend_link == LINK_UP) ? axv[2] : 16'd0;
      right_y       <= (pend_link == LINK_UP) ? axv[3] : 16'd0;
    end
  end

  assign sts.emit_frame = emit_frame;
  assign sts.emit_down  = emit_down;
  assign sts.div_busy   = div_busy;
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gamepad_frame_receiver. Streams bytes, ticks and
// overflow marks through the request port across several register settings.
// A built-in frame and axis predictor checks every report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gfr_pkg::*;

  // register indexes and the unused item code
  localparam logic [1:0] REG_DEADZONE = 2'd0;
  localparam logic [1:0] REG_FRAME_TO = 2'd1;
  localparam logic [1:0] REG_OFFLINE_TO = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;
  localparam logic [16:0] AGE_SAT = 17'h1FFFF;

  typedef struct {
    logic [1:0] op;
    logic [7:0] b;
  } req_t;

  typedef struct {
    logic [1:0]         link;
    logic [15:0]        btn;
    logic [15:0]        prs;
    logic [15:0]        rel;
    logic [31:0]        evt;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [31:0]        frm;
    logic [31:0]        sig;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [7:0] data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] link_status;
  logic [15:0] buttons, pressed, released;
  logic [31:0] event_total, frames_total, signals_total;
  logic signed [15:0] left_x, left_y, right_x, right_y;

  gamepad_frame_receiver u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .link_status(link_status), .buttons(buttons), .pressed(pressed),
    .released(released), .event_total(event_total),
    .left_x(left_x), .left_y(left_y), .right_x(right_x), .right_y(right_y),
    .frames_total(frames_total), .signals_total(signals_total)
  );

  // predictor state
  logic [14:0] dz_reg;
  logic [15:0] frame_to, offline_to;
  logic [7:0]  fbytes [8];
  int unsigned fill;
  logic [16:0] part_age, quiet_age;
  logic [1:0]  link_now;
  logic [15:0] held_btn;
  logic [31:0] evt_cnt, frm_cnt, sig_cnt;

  req_t    pend_q [$];
  report_t want_q [$];
  int      fail_cnt = 0;
  int      items_made = 0;
  bit      sending = 0;
  bit      burst_mode = 0;
  logic [15:0] last_btn = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic void norm_axis(input int raw, input int mid,
                                    output int num, output int den);
    if (raw >= mid) begin
      num = raw - mid;
      den = 255 - mid;
    end else begin
      num = -(mid - raw);
      den = mid;
    end
  endfunction

  function automatic logic signed [15:0] scale_axis(input int n, input int d,
      input longint unsigned mn, input longint unsigned md);
    longint unsigned an, dz, top, bot, q;
    an = (n < 0) ? -n : n;
    dz = dz_reg;
    top = 64'd32768 * an * (64'd32768 * mn - dz * md);
    bot = d * mn * (64'd32768 - dz);
    q = (top + bot / 2) / bot;
    if (n < 0) return -$signed(q[16:0]);
    return (q > 32767) ? 16'sd32767 : q[15:0];
  endfunction

  function automatic void stick_out(input int xn, input int xd, input int yn, input int yd,
      output logic signed [15:0] ox, output logic signed [15:0] oy);
    longint unsigned ax, ay, mn, md;
    ax = (xn < 0) ? -xn : xn;
    ay = (yn < 0) ? -yn : yn;
    if (ax * yd >= ay * xd) begin
      mn = ax;
      md = xd;
    end else begin
      mn = ay;
      md = yd;
    end
    if (mn * 32768 <= dz_reg * md) begin
      ox = 0;
      oy = 0;
    end else begin
      ox = scale_axis(xn, xd, mn, md);
      oy = scale_axis(yn, yd, mn, md);
    end
  endfunction

  function automatic report_t link_down(input logic [1:0] code);
    report_t r;
    r = '{default: '0};
    r.rel = held_btn;
    if (held_btn != 0) evt_cnt++;
    held_btn = '0;
    link_now = code;
    r.link = code;
    r.evt = evt_cnt;
    r.frm = frm_cnt;
    r.sig = sig_cnt;
    return r;
  endfunction

  function automatic report_t frame_report();
    report_t r;
    int lxn, lxd, lyn, lyd, rxn, rxd, ryn, ryd;
    logic [15:0] cur;
    cur = {fbytes[1], fbytes[2]};
    r.link = LINK_UP;
    r.btn = cur;
    r.prs = cur & ~held_btn;
    r.rel = held_btn & ~cur;
    norm_axis(fbytes[4], 127, lxn, lxd);
    norm_axis(fbytes[3], 128, lyn, lyd);
    norm_axis(fbytes[6], 127, rxn, rxd);
    norm_axis(fbytes[5], 128, ryn, ryd);
    stick_out(lxn, lxd, -lyn, lyd, r.lx, r.ly);
    stick_out(rxn, rxd, -ryn, ryd, r.rx, r.ry);
    if ((r.prs | r.rel) != 0) evt_cnt++;
    held_btn = cur;
    frm_cnt++;
    sig_cnt++;
    quiet_age = '0;
    link_now = LINK_UP;
    r.evt = evt_cnt;
    r.frm = frm_cnt;
    r.sig = sig_cnt;
    return r;
  endfunction

  // advance the predictor by one accepted request
  function automatic void predict_step(input req_t q);
    int i;
    bit found;
    if (q.op == OP_TICK) begin
      if (fill != 0) begin
        if (part_age < AGE_SAT) part_age++;
        if (part_age > frame_to) begin
          fill = 0;
          part_age = '0;
        end
      end
      if (quiet_age < AGE_SAT) quiet_age++;
      if (quiet_age > offline_to && link_now != LINK_OFF) want_q.push_back(link_down(LINK_OFF));
    end else if (q.op == OP_OVF) begin
      fill = 0;
      part_age = '0;
    end else if (q.op == OP_BYTE) begin
      if (fill == 0) begin
        if (q.b == HEAD_BYTE) begin
          fbytes[0] = q.b;
          fill = 1;
          part_age = '0;
        end else if (q.b == GONE_BYTE) begin
          sig_cnt++;
          quiet_age = '0;
          want_q.push_back(link_down(LINK_GONE));
        end
      end else begin
        fbytes[fill] = q.b;
        fill++;
        part_age = '0;
        if (fill == 8) begin
          if (fbytes[0] == HEAD_BYTE && fbytes[7] == TAIL_BYTE) begin
            fill = 0;
            want_q.push_back(frame_report());
          end else begin
            // resync on the latest header past index 0
            found = 0;
            for (i = 7; i >= 1 && !found; i--) begin
              if (fbytes[i] == HEAD_BYTE) begin
                for (int k = 0; k < 8 - i; k++) fbytes[k] = fbytes[k + i];
                fill = 8 - i;
                found = 1;
              end
            end
            if (!found) fill = 0;
          end
        end
      end
    end
  endfunction

  // ---------------- driver ----------------
  int send_gap = 0;
  always @(posedge clk) begin
    req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        nxt.op = opcode;
        nxt.b = data_byte;
        predict_step(nxt);
        sending = 0;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          nxt = pend_q.pop_front();
          sending = 1;
          in_valid <= 1'b1;
          opcode <= nxt.op;
          data_byte <= nxt.b;
          send_gap = burst_mode ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int hold_left = 0;
  int wait_left = 0;
  int seen = 0;

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    report_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          $error("report with none expected");
          fail_cnt++;
        end else begin
          w = want_q.pop_front();
          check_field("link_status", w.link, link_status);
          check_field("buttons", w.btn, buttons);
          check_field("pressed", w.prs, pressed);
          check_field("released", w.rel, released);
          check_field("event_total", w.evt, event_total);
          check_field("left_x", w.lx, left_x);
          check_field("left_y", w.ly, left_y);
          check_field("right_x", w.rx, right_x);
          check_field("right_y", w.ry, right_y);
          check_field("frames_total", w.frm, frames_total);
          check_field("signals_total", w.sig, signals_total);
        end
        seen++;
        // long back-pressure so the block fills and stalls its input
        if (seen == 40 || seen == 160) hold_left = 600;
        else wait_left = burst_mode ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_req(input logic [1:0] op, input logic [7:0] b);
    req_t q;
    q.op = op;
    q.b = b;
    pend_q.push_back(q);
    items_made++;
  endtask

  task automatic push_frame(input logic [15:0] btn, input logic [7:0] ly, input logic [7:0] lx,
                            input logic [7:0] ry, input logic [7:0] rx);
    push_req(OP_BYTE, HEAD_BYTE);
    push_req(OP_BYTE, btn[15:8]);
    push_req(OP_BYTE, btn[7:0]);
    push_req(OP_BYTE, ly);
    push_req(OP_BYTE, lx);
    push_req(OP_BYTE, ry);
    push_req(OP_BYTE, rx);
    push_req(OP_BYTE, TAIL_BYTE);
  endtask

  function automatic logic [7:0] axis_raw();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(118, 137));
      2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(96, 160));
    endcase
  endfunction

  task automatic push_random(input int n);
    int stop;
    int k;
    logic [15:0] btn;
    stop = items_made + n;
    while (items_made < stop) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        btn = ($urandom_range(0, 3) == 0) ? last_btn : 16'($urandom());
        last_btn = btn;
        push_frame(btn, axis_raw(), axis_raw(), axis_raw(), axis_raw());
      end else if (k < 62) begin
        push_req(OP_BYTE, GONE_BYTE);
      end else if (k < 75) begin
        repeat ($urandom_range(1, 6)) push_req(OP_TICK, 8'($urandom()));
      end else if (k < 80) begin
        push_req(OP_OVF, 8'($urandom()));
      end else if (k < 84) begin
        push_req(OP_RSVD, 8'($urandom()));
      end else if (k < 94) begin
        // broken frame: header, a few bytes with maybe a header inside
        push_req(OP_BYTE, HEAD_BYTE);
        repeat ($urandom_range(1, 7))
          push_req(OP_BYTE, ($urandom_range(0, 3) == 0) ? HEAD_BYTE : 8'($urandom()));
      end else begin
        push_req(OP_BYTE, 8'($urandom()));
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_DEADZONE: dz_reg = val[14:0];
      REG_FRAME_TO: frame_to = val;
      REG_OFFLINE_TO: offline_to = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || sending || want_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] dz, input logic [15:0] ft, input logic [15:0] ot);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_FRAME_TO, ft);
    write_reg(REG_OFFLINE_TO, ot);
  endtask

  initial begin
    dz_reg = 15'd3277;
    frame_to = 16'd100;
    offline_to = 16'd1000;
    for (int i = 0; i < 8; i++) fbytes[i] = '0;
    fill = 0;
    part_age = '0;
    quiet_age = '0;
    link_now = LINK_OFF;
    held_btn = '0;
    evt_cnt = '0;
    frm_cnt = '0;
    sig_cnt = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, each item kind, resync, disconnect, timeouts
    set_regs(16'd0, 16'd2, 16'd5);
    push_frame(16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0);
    push_frame(16'h0000, 8'd255, 8'd255, 8'd255, 8'd255);
    push_frame(16'hA55A, 8'd128, 8'd127, 8'd128, 8'd127);
    push_req(OP_BYTE, GONE_BYTE);
    push_req(OP_BYTE, 8'h55);
    push_req(OP_RSVD, 8'hFF);
    push_req(OP_BYTE, HEAD_BYTE);
    push_req(OP_OVF, 8'h00);
    push_req(OP_BYTE, HEAD_BYTE);
    push_req(OP_BYTE, 8'h01);
    push_req(OP_BYTE, HEAD_BYTE);
    repeat (5) push_req(OP_BYTE, 8'h33);
    push_req(OP_BYTE, TAIL_BYTE);
    repeat (8) push_req(OP_TICK, 8'h00);
    push_req(OP_BYTE, HEAD_BYTE);
    repeat (4) push_req(OP_TICK, 8'h00);
    drain();

    push_random(90);
    drain();

    set_regs(16'hFFFF, 16'd0, 16'd0);
    push_random(70);
    drain();

    // sender pauses mid-phase until every report is back
    set_regs(16'd3277, 16'd3, 16'd12);
    push_random(45);
    while (pend_q.size() != 0 || sending || want_q.size() != 0) @(posedge clk);
    push_random(45);
    drain();

    burst_mode = 1;
    set_regs(16'd16384, 16'd65535, 16'd65535);
    push_random(70);
    drain();
    burst_mode = 0;

    set_regs(16'($urandom_range(0, 32767)), 16'($urandom_range(1, 8)),
             16'($urandom_range(4, 40)));
    push_random(70);
    drain();

    set_regs(16'd1, 16'd1, 16'd1);
    push_random(70);
    drain();

    if (fail_cnt == 0 && want_q.size() == 0) begin
      $display("PASS gamepad_frame_receiver");
    end else begin
      $display("FAIL gamepad_frame_receiver");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL gamepad_frame_receiver");
    $finish;
  end

endmodule
